FILE: rtl/ttrq_pkg.sv
// ----------------------------------------------------------------------------
// ttrq_pkg
// Shared types and constants of the timed task ready queue: request and
// result codes, controller states and the control groups between modules.
// ----------------------------------------------------------------------------
package ttrq_pkg;

   localparam int unsigned DEF_TABLE_DEPTH = 16;
   localparam int unsigned DEF_TIME_BITS   = 32;
   localparam int unsigned ID_BITS         = 8;

   typedef enum logic {
      OP_ADD  = 1'b0,
      OP_TAKE = 1'b1
   } op_type;

   typedef enum logic [1:0] {
      STAT_ADDED = 2'd0,
      STAT_FULL  = 2'd1,
      STAT_TAKEN = 2'd2,
      STAT_NONE  = 2'd3
   } status_type;

   typedef enum logic [1:0] {
      S_IDLE,
      S_EVAL,
      S_TAKE,
      S_SCAN
   } state_type;

   // commands from the controller to every cell
   typedef struct packed {
      logic eval;
      logic ins;
      logic take_phase;
      logic rm_due;
      logic scan_start;
      logic scan_step;
      logic scan_phase;
      logic rm_scan;
      logic scan_clear;
   } cmd_type;

   // per-cell flags seen by the neighbor and the top level
   typedef struct packed {
      logic vld;
      logic stay;
      logic hit_due;
      logic hit_mar;
      logic tok;
   } flag_type;

   // search status back to the controller
   typedef struct packed {
      logic hit;
      logic scan_end;
   } stat_type;

endpackage

FILE: rtl/ttrq_cell.sv
// ----------------------------------------------------------------------------
// ttrq_cell
// One table slot: holds a task, compares it against the current request and
// shifts toward its neighbors on insert and remove.
// ----------------------------------------------------------------------------
module ttrq_cell import ttrq_pkg::*; #(
   parameter int unsigned TIME_BITS = DEF_TIME_BITS
) (
   input  logic                 clock,
   input  logic                 reset,
   input  cmd_type              cmd,
   input  logic [ID_BITS-1:0]   new_id,
   input  logic [TIME_BITS-1:0] new_due,
   input  logic [TIME_BITS-1:0] new_margin,
   input  logic [TIME_BITS-1:0] cur_now,
   input  flag_type             prev_flag,
   input  logic [ID_BITS-1:0]   prev_id,
   input  logic [TIME_BITS-1:0] prev_due,
   input  logic [TIME_BITS-1:0] prev_margin,
   input  logic                 next_vld,
   input  logic [ID_BITS-1:0]   next_id,
   input  logic [TIME_BITS-1:0] next_due,
   input  logic [TIME_BITS-1:0] next_margin,
   output flag_type             flag,
   output logic [ID_BITS-1:0]   id,
   output logic [TIME_BITS-1:0] due,
   output logic [TIME_BITS-1:0] margin,
   output logic                 pick,
   output logic [ID_BITS-1:0]   pick_id
);

   logic                 vld_ff, vld_in;
   logic [ID_BITS-1:0]   id_ff, id_in;
   logic [TIME_BITS-1:0] due_ff, due_in;
   logic [TIME_BITS-1:0] margin_ff, margin_in;
   logic                 hit_due_ff, hit_due_in;
   logic                 hit_mar_ff, hit_mar_in;
   logic                 tok_ff, tok_in;
   logic                 before_ff, before_in;

   logic                 stay;
   logic                 hit_due_now;
   logic                 hit_mar_now;
   logic [TIME_BITS:0]   mar_sum;
   logic                 first_due;

   assign stay        = vld_ff && (new_due < due_ff);
   assign hit_due_now = vld_ff && (cur_now >= due_ff);
   assign mar_sum     = {1'b0, cur_now} + {1'b0, margin_ff};
   assign hit_mar_now = vld_ff && (mar_sum >= {1'b0, due_ff});
   assign first_due   = hit_due_ff && !prev_flag.hit_due;

   assign pick    = (cmd.take_phase && first_due) ||
                    (cmd.scan_phase && tok_ff && hit_mar_ff);
   assign pick_id = pick ? id_ff : '0;

   assign flag = '{vld: vld_ff, stay: stay, hit_due: hit_due_ff,
                   hit_mar: hit_mar_ff, tok: tok_ff};
   assign id     = id_ff;
   assign due    = due_ff;
   assign margin = margin_ff;

   always_comb begin
      vld_in    = vld_ff;
      id_in     = id_ff;
      due_in    = due_ff;
      margin_in = margin_ff;
      if (cmd.ins && !stay) begin
         if (prev_flag.stay) begin
            vld_in    = 1'b1;
            id_in     = new_id;
            due_in    = new_due;
            margin_in = new_margin;
         end else begin
            vld_in    = prev_flag.vld;
            id_in     = prev_id;
            due_in    = prev_due;
            margin_in = prev_margin;
         end
      end else if ((cmd.rm_due && hit_due_ff) || (cmd.rm_scan && !before_ff)) begin
         vld_in    = next_vld;
         id_in     = next_id;
         due_in    = next_due;
         margin_in = next_margin;
      end
   end

   always_comb begin
      hit_due_in = hit_due_ff;
      hit_mar_in = hit_mar_ff;
      if (cmd.eval) begin
         hit_due_in = hit_due_now;
         hit_mar_in = hit_mar_now;
      end
   end

   // search token walks one cell per cycle while the controller steps the scan
   always_comb begin
      tok_in    = tok_ff;
      before_in = before_ff;
      if (cmd.scan_clear) begin
         tok_in    = 1'b0;
         before_in = 1'b0;
      end else if (cmd.scan_start || cmd.scan_step) begin
         tok_in    = prev_flag.tok;
         before_in = before_ff | tok_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff    <= 1'b0;
         tok_ff    <= 1'b0;
         before_ff <= 1'b0;
      end else begin
         vld_ff    <= vld_in;
         tok_ff    <= tok_in;
         before_ff <= before_in;
      end
   end

   always_ff @(posedge clock) begin
      id_ff      <= id_in;
      due_ff     <= due_in;
      margin_ff  <= margin_in;
      hit_due_ff <= hit_due_in;
      hit_mar_ff <= hit_mar_in;
   end

endmodule

FILE: rtl/ttrq_ctrl.sv
// ----------------------------------------------------------------------------
// ttrq_ctrl
// Request sequencer: latches a request, steps the cell row through compare,
// search and shift, and holds the result in the output register.
// ----------------------------------------------------------------------------
module ttrq_ctrl import ttrq_pkg::*; #(
   parameter int unsigned TIME_BITS = DEF_TIME_BITS
) (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_valid,
   output logic                 req_stall,
   input  logic                 req_op,
   input  logic [ID_BITS-1:0]   req_task_id,
   input  logic [TIME_BITS-1:0] req_due_time,
   input  logic [TIME_BITS-1:0] req_early_margin,
   input  logic [TIME_BITS-1:0] req_now,
   output logic                 rsp_valid,
   input  logic                 rsp_stall,
   output logic [1:0]           rsp_status,
   output logic [ID_BITS-1:0]   rsp_taken_id,
   input  logic                 full,
   input  stat_type             stat,
   input  logic [ID_BITS-1:0]   sel_id,
   output cmd_type              cmd,
   output logic [ID_BITS-1:0]   cur_id,
   output logic [TIME_BITS-1:0] cur_due,
   output logic [TIME_BITS-1:0] cur_margin,
   output logic [TIME_BITS-1:0] cur_now
);

   state_type            state_ff, state_in;
   op_type               op_ff;
   logic [ID_BITS-1:0]   id_ff;
   logic [TIME_BITS-1:0] due_ff;
   logic [TIME_BITS-1:0] margin_ff;
   logic [TIME_BITS-1:0] now_ff;
   logic                 rsp_valid_ff, rsp_valid_in;
   status_type           rsp_status_ff, rsp_status_in;
   logic [ID_BITS-1:0]   rsp_id_ff, rsp_id_in;

   logic                 accept;
   logic                 slot_free;
   logic                 done;
   status_type           done_status;
   logic [ID_BITS-1:0]   done_id;

   assign req_stall = reset || (state_ff != S_IDLE);
   assign accept    = req_valid && !req_stall;
   assign slot_free = !rsp_valid_ff || !rsp_stall;

   assign cur_id     = id_ff;
   assign cur_due    = due_ff;
   assign cur_margin = margin_ff;
   assign cur_now    = now_ff;

   assign rsp_valid    = rsp_valid_ff;
   assign rsp_status   = rsp_status_ff;
   assign rsp_taken_id = rsp_id_ff;

   always_comb begin
      state_in = state_ff;
      case (state_ff)
         S_IDLE: begin
            if (accept) state_in = S_EVAL;
         end
         S_EVAL: begin
            if (op_ff == OP_TAKE) state_in = S_TAKE;
            else if (slot_free) state_in = S_IDLE;
         end
         S_TAKE: begin
            if (!stat.hit) state_in = S_SCAN;
            else if (slot_free) state_in = S_IDLE;
         end
         S_SCAN: begin
            if ((stat.hit || stat.scan_end) && slot_free) state_in = S_IDLE;
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_comb begin
      cmd         = '0;
      done        = 1'b0;
      done_status = STAT_NONE;
      done_id     = '0;
      case (state_ff)
         S_EVAL: begin
            cmd.eval = 1'b1;
            if (op_ff == OP_ADD && slot_free) begin
               done = 1'b1;
               if (full) begin
                  done_status = STAT_FULL;
               end else begin
                  cmd.ins     = 1'b1;
                  done_status = STAT_ADDED;
               end
            end
         end
         S_TAKE: begin
            cmd.take_phase = 1'b1;
            if (stat.hit) begin
               if (slot_free) begin
                  cmd.rm_due  = 1'b1;
                  done        = 1'b1;
                  done_status = STAT_TAKEN;
                  done_id     = sel_id;
               end
            end else begin
               cmd.scan_start = 1'b1;
            end
         end
         S_SCAN: begin
            cmd.scan_phase = 1'b1;
            if (stat.hit) begin
               if (slot_free) begin
                  cmd.rm_scan    = 1'b1;
                  cmd.scan_clear = 1'b1;
                  done           = 1'b1;
                  done_status    = STAT_TAKEN;
                  done_id        = sel_id;
               end
            end else if (stat.scan_end) begin
               if (slot_free) begin
                  cmd.scan_clear = 1'b1;
                  done           = 1'b1;
                  done_status    = STAT_NONE;
               end
            end else begin
               cmd.scan_step = 1'b1;
            end
         end
         default: begin
            cmd = '0;
         end
      endcase
   end

   always_comb begin
      rsp_valid_in  = rsp_valid_ff;
      rsp_status_in = rsp_status_ff;
      rsp_id_in     = rsp_id_ff;
      if (done) begin
         rsp_valid_in  = 1'b1;
         rsp_status_in = done_status;
         rsp_id_in     = done_id;
      end else if (!rsp_stall) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      rsp_status_ff <= rsp_status_in;
      rsp_id_ff     <= rsp_id_in;
      if (accept) begin
         op_ff     <= op_type'(req_op);
         id_ff     <= req_task_id;
         due_ff    <= req_due_time;
         margin_ff <= req_early_margin;
         now_ff    <= req_now;
      end
   end

endmodule

FILE: rtl/timed_task_ready_queue.sv
// ----------------------------------------------------------------------------
// timed_task_ready_queue
// Bounded table of pending tasks kept latest-due first in a row of cells;
// adds insert in order, takes remove the first due or early-runnable task.
//
//   channel   direction  handshake             payload
//   req_      in         req_valid/req_stall   op, task_id, due_time,
//                                              early_margin, now
//   rsp_      out        rsp_valid/rsp_stall   status, taken_id
//
// add: latch, then compare and shift in every cell at once
// take: latch, evaluate, then remove the first due task when one exists;
//   otherwise the early-margin search token walks one cell per cycle while
//   no early-runnable task is found and the end of the table is not reached
// reset clears the occupancy, search and response-valid bits and the
//   controller state, not the task data; the block is ready as soon as reset drops
// a stalled result keeps its slot; the next request is accepted and waits
//   at its last step until the output register frees
// ----------------------------------------------------------------------------
module timed_task_ready_queue import ttrq_pkg::*; #(
   parameter int unsigned TABLE_DEPTH = DEF_TABLE_DEPTH,
   parameter int unsigned TIME_BITS   = DEF_TIME_BITS
) (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_valid,
   output logic                 req_stall,
   input  logic                 req_op,
   input  logic [ID_BITS-1:0]   req_task_id,
   input  logic [TIME_BITS-1:0] req_due_time,
   input  logic [TIME_BITS-1:0] req_early_margin,
   input  logic [TIME_BITS-1:0] req_now,
   output logic                 rsp_valid,
   input  logic                 rsp_stall,
   output logic [1:0]           rsp_status,
   output logic [ID_BITS-1:0]   rsp_taken_id
);

   cmd_type              cmd;
   stat_type             stat;
   logic                 full;
   logic [ID_BITS-1:0]   sel_id;
   logic [ID_BITS-1:0]   cur_id;
   logic [TIME_BITS-1:0] cur_due;
   logic [TIME_BITS-1:0] cur_margin;
   logic [TIME_BITS-1:0] cur_now;

   flag_type             cell_flag   [TABLE_DEPTH];
   logic [ID_BITS-1:0]   cell_id     [TABLE_DEPTH];
   logic [TIME_BITS-1:0] cell_due    [TABLE_DEPTH];
   logic [TIME_BITS-1:0] cell_margin [TABLE_DEPTH];
   logic [ID_BITS-1:0]   cell_pick_id[TABLE_DEPTH];
   logic [TABLE_DEPTH-1:0] pick_vec;
   logic [TABLE_DEPTH-1:0] tok_vec;

   ttrq_ctrl #(
      .TIME_BITS(TIME_BITS)
   ) u_ctrl (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_stall        (req_stall),
      .req_op           (req_op),
      .req_task_id      (req_task_id),
      .req_due_time     (req_due_time),
      .req_early_margin (req_early_margin),
      .req_now          (req_now),
      .rsp_valid        (rsp_valid),
      .rsp_stall        (rsp_stall),
      .rsp_status       (rsp_status),
      .rsp_taken_id     (rsp_taken_id),
      .full             (full),
      .stat             (stat),
      .sel_id           (sel_id),
      .cmd              (cmd),
      .cur_id           (cur_id),
      .cur_due          (cur_due),
      .cur_margin       (cur_margin),
      .cur_now          (cur_now)
   );

   for (genvar g = 0; g < TABLE_DEPTH; g++) begin : g_cell
      flag_type             prev_flag;
      logic [ID_BITS-1:0]   prev_id;
      logic [TIME_BITS-1:0] prev_due;
      logic [TIME_BITS-1:0] prev_margin;
      logic                 next_vld;
      logic [ID_BITS-1:0]   next_id;
      logic [TIME_BITS-1:0] next_due;
      logic [TIME_BITS-1:0] next_margin;

      // head sees a neighbor that always stays and hands in the start token
      if (g == 0) begin : g_head
         assign prev_flag   = '{vld: 1'b0, stay: 1'b1, hit_due: 1'b0,
                                hit_mar: 1'b0, tok: cmd.scan_start};
         assign prev_id     = '0;
         assign prev_due    = '0;
         assign prev_margin = '0;
      end else begin : g_link_prev
         assign prev_flag   = cell_flag[g-1];
         assign prev_id     = cell_id[g-1];
         assign prev_due    = cell_due[g-1];
         assign prev_margin = cell_margin[g-1];
      end

      if (g == TABLE_DEPTH - 1) begin : g_tail
         assign next_vld    = 1'b0;
         assign next_id     = '0;
         assign next_due    = '0;
         assign next_margin = '0;
      end else begin : g_link_next
         assign next_vld    = cell_flag[g+1].vld;
         assign next_id     = cell_id[g+1];
         assign next_due    = cell_due[g+1];
         assign next_margin = cell_margin[g+1];
      end

      ttrq_cell #(
         .TIME_BITS(TIME_BITS)
      ) u_cell (
         .clock       (clock),
         .reset       (reset),
         .cmd         (cmd),
         .new_id      (cur_id),
         .new_due     (cur_due),
         .new_margin  (cur_margin),
         .cur_now     (cur_now),
         .prev_flag   (prev_flag),
         .prev_id     (prev_id),
         .prev_due    (prev_due),
         .prev_margin (prev_margin),
         .next_vld    (next_vld),
         .next_id     (next_id),
         .next_due    (next_due),
         .next_margin (next_margin),
         .flag        (cell_flag[g]),
         .id          (cell_id[g]),
         .due         (cell_due[g]),
         .margin      (cell_margin[g]),
         .pick        (pick_vec[g]),
         .pick_id     (cell_pick_id[g])
      );

      assign tok_vec[g] = cell_flag[g].tok;
   end

   assign full = cell_flag[TABLE_DEPTH-1].vld;

   always_comb begin
      stat   = '0;
      sel_id = '0;
      for (int i = 0; i < TABLE_DEPTH; i++) begin
         stat.hit      = stat.hit | pick_vec[i];
         sel_id        = sel_id | cell_pick_id[i];
         stat.scan_end = stat.scan_end | (cell_flag[i].tok & ~cell_flag[i].vld);
      end
      stat.scan_end = stat.scan_end |
                      (cell_flag[TABLE_DEPTH-1].tok & ~cell_flag[TABLE_DEPTH-1].hit_mar);
   end

`ifndef SYNTHESIS
   a_ins_not_full: assert property (@(posedge clock) disable iff (reset)
      cmd.ins |-> !full)
      else $error("insert into a full table");

   a_rm_needs_hit: assert property (@(posedge clock) disable iff (reset)
      (cmd.rm_due || cmd.rm_scan) |-> stat.hit)
      else $error("remove without a selected entry");

   a_tok_onehot: assert property (@(posedge clock) disable iff (reset)
      $onehot0(tok_vec))
      else $error("more than one search token");

   a_pick_onehot: assert property (@(posedge clock) disable iff (reset)
      $onehot0(pick_vec))
      else $error("more than one cell selected");

   a_id_zero: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_status != STAT_TAKEN) |-> (rsp_taken_id == '0))
      else $error("taken id set on a non-take result");
`endif

endmodule
